FILE: sv/scaled_divide_coprocessor_top_defines.svh
// ----------------------------------------------------------------------------
// scaled divide coprocessor assertion macros
// shared concurrent assertion shorthands for the rtl
// ----------------------------------------------------------------------------
`ifndef SCALED_DIVIDE_COPROCESSOR_TOP_DEFINES_SVH
`define SCALED_DIVIDE_COPROCESSOR_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define SDC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SDC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg
// types, codes and constants of the scaled divide coprocessor
// ----------------------------------------------------------------------------
package sdc_pkg;

    // bus function codes
    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_READ_LO = 2'd1;
    localparam logic [1:0] FUNC_READ_HI = 2'd2;
    localparam logic [1:0] FUNC_STATUS  = 2'd3;

    // register addresses that are kept
    localparam logic [4:0] ADDR_EXPONENT  = 5'h0C;
    localparam logic [4:0] ADDR_NUMERATOR = 5'h0E;
    localparam logic [4:0] ADDR_DIV_HIGH  = 5'h16;
    localparam logic [4:0] ADDR_DIV_LOW   = 5'h15;

    localparam int NUM_W      = 8;
    localparam int EXP_W      = 5;                        // exponent 0..31
    localparam int DIVISOR_W  = 16;
    localparam int QUOT_W     = 16;
    localparam int RESULT_SHIFT = 8;
    localparam int DIVIDEND_W = NUM_W + (1 << EXP_W) - 1; // 39 bits
    // quotient bits below the result shift are never needed
    localparam int DIV_STEPS  = DIVIDEND_W - RESULT_SHIFT;
    localparam int COUNT_W    = $clog2(DIV_STEPS);

    localparam logic [7:0] STATUS_IDLE = 8'h00;
    localparam logic [7:0] FAULT_BYTE  = 8'hFF;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CALC
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [NUM_W-1:0]     numerator;
        logic [EXP_W-1:0]     exponent;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: sv/sdc_div.sv
// ----------------------------------------------------------------------------
// sdc_div
// restoring divider, one quotient bit per cycle, keeps quotient bits 23..8
// ----------------------------------------------------------------------------
module sdc_div
    import sdc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [DIVIDEND_W-1:0] dividend_reg, dividend_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // trial subtract of the shifted-in dividend bit
    assign trial = {rem_reg, dividend_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        count_next    = count_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        if (req.start) begin
            busy_next     = 1'b1;
            count_next    = '0;
            dividend_next = DIVIDEND_W'(req.numerator) << req.exponent;
            divisor_next  = req.divisor;
            rem_next      = '0;
            quot_next     = '0;
        end else if (busy_reg) begin
            rem_next      = fits ? DIVISOR_W'(trial - {1'b0, divisor_reg})
                                 : trial[DIVISOR_W-1:0];
            quot_next     = {quot_reg[QUOT_W-2:0], fits};
            dividend_next = {dividend_reg[DIVIDEND_W-2:0], 1'b0};
            count_next    = count_reg + 1'b1;
            if (count_reg == COUNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

FILE: sv/scaled_divide_coprocessor_top.sv
// ----------------------------------------------------------------------------
// scaled_divide_coprocessor_top
// byte-wide bus helper returning ((numerator << exponent) / divisor) >> 8
// ----------------------------------------------------------------------------
// every bus access is one input item and gives exactly one result item. a
// write (func 0) stores a byte at exponent 0x0C, numerator 0x0E, divisor
// low 0x15 or divisor high 0x16 and returns 0; other addresses are dropped.
// a status read (func 3) returns 0. a result read (func 1 low byte, func 2
// high byte) returns a byte of the 16-bit truncated quotient. a zero divisor
// or an exponent above 31 gives 0xff with fault set, straight away. writes,
// status reads and faulting reads load the output register in the cycle
// after the item is taken. a computed read runs the shared restoring
// divider over dividend bits 38 down to 8, one quotient bit for each; on
// the divider's registered done flag the chosen quotient byte is loaded
// into the output register, and s_ready stays low until then. the result
// sits in an output register, and a new item is taken in the same cycle
// that the waiting result is taken.
// ----------------------------------------------------------------------------
`include "scaled_divide_coprocessor_top_defines.svh"

module scaled_divide_coprocessor_top
    import sdc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // input items
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [4:0] s_address,
    input  logic [7:0] s_value,
    // result items
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_fault
);

    // operand bytes
    logic [7:0] exponent_reg;
    logic [7:0] numerator_reg;
    logic [7:0] div_high_reg;
    logic [7:0] div_low_reg;

    // control
    state_t     state_reg, state_next;
    logic       sel_high_reg, sel_high_next;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_read_data_reg, m_read_data_next;
    logic       m_fault_reg, m_fault_next;

    logic                 accept;
    logic                 out_free;
    logic                 load_out;
    logic                 div_start;
    logic                 operands_bad;
    logic [DIVISOR_W-1:0] divisor;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    // output slot is free, or its item leaves this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign divisor      = {div_high_reg, div_low_reg};
    // exponent above 31 means a set bit above the low five
    assign operands_bad = (divisor == '0) || (exponent_reg[7:EXP_W] != '0);

    assign div_req.start     = div_start;
    assign div_req.numerator = numerator_reg;
    assign div_req.exponent  = exponent_reg[EXP_W-1:0];
    assign div_req.divisor   = divisor;

    // sequencer: next state and output register loading
    always_comb begin
        state_next       = state_reg;
        sel_high_next    = sel_high_reg;
        load_out         = 1'b0;
        m_read_data_next = m_read_data_reg;
        m_fault_next     = m_fault_reg;
        div_start        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_func) inside
                        FUNC_READ_LO, FUNC_READ_HI: begin
                            sel_high_next = (s_func == FUNC_READ_HI);
                            if (operands_bad) begin
                                // undefined cases answer at once
                                load_out         = 1'b1;
                                m_read_data_next = FAULT_BYTE;
                                m_fault_next     = 1'b1;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_CALC;
                            end
                        end
                        FUNC_WRITE: begin
                            load_out         = 1'b1;
                            m_read_data_next = '0;
                            m_fault_next     = 1'b0;
                        end
                        FUNC_STATUS: begin
                            load_out         = 1'b1;
                            m_read_data_next = STATUS_IDLE;
                            m_fault_next     = 1'b0;
                        end
                        default: begin
                            load_out         = 1'b1;
                            m_read_data_next = '0;
                            m_fault_next     = 1'b0;
                        end
                    endcase
                end
            end
            ST_CALC: begin
                // output slot was emptied at accept, nothing fills it meanwhile
                if (div_rsp.done) begin
                    load_out         = 1'b1;
                    m_read_data_next = sel_high_reg ? div_rsp.quotient[15:8]
                                                    : div_rsp.quotient[7:0];
                    m_fault_next     = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_high_reg    <= sel_high_next;
        m_read_data_reg <= m_read_data_next;
        m_fault_reg     <= m_fault_next;
    end

    // operand byte writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg  <= '0;
            numerator_reg <= '0;
            div_high_reg  <= '0;
            div_low_reg   <= '0;
        end else if (accept && (s_func == FUNC_WRITE)) begin
            unique case (s_address)
                ADDR_EXPONENT:  exponent_reg  <= s_value;
                ADDR_NUMERATOR: numerator_reg <= s_value;
                ADDR_DIV_HIGH:  div_high_reg  <= s_value;
                ADDR_DIV_LOW:   div_low_reg   <= s_value;
                default: ;
            endcase
        end
    end

    // shared iterative divider
    sdc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_fault     = m_fault_reg;

    // checks
    `SDC_ASSERT_NEXT(a_read_starts_calc, aclk, aresetn,
        accept && (s_func == FUNC_READ_LO || s_func == FUNC_READ_HI) && !operands_bad,
        state_reg == ST_CALC && !m_valid_reg, "good read did not start the divider")
    `SDC_ASSERT_SAME(a_done_only_in_calc, aclk, aresetn,
        div_rsp.done, state_reg == ST_CALC, "divider finished outside a calculation")
    `SDC_ASSERT_SAME(a_calc_output_empty, aclk, aresetn,
        state_reg == ST_CALC, !m_valid_reg, "result pending while dividing")
    `SDC_ASSERT_SAME(a_fault_byte, aclk, aresetn,
        m_valid_reg && m_fault_reg, m_read_data_reg == FAULT_BYTE, "fault without 0xff data")

endmodule
